// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the relocator RTL.
// Expects clk and an active-low rst_n in the including module's scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define MOR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define MOR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/mor_pkg.sv -----
// Relocator package: relocation type codes, section codes, register indexes.
// No dependencies.
package mor_pkg;

  localparam int ENTRY_W = 32;
  localparam int WORD_W  = 32;
  localparam int ADDR_W  = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [5:0] RT_WORD32 = 6'd2;
  localparam logic [5:0] RT_JUMP26 = 6'd4;
  localparam logic [5:0] RT_HI16   = 6'd5;
  localparam logic [5:0] RT_LO16   = 6'd6;

  localparam logic [1:0] SEC_NULL   = 2'd0;
  localparam logic [1:0] SEC_TEXT   = 2'd1;
  localparam logic [1:0] SEC_DATA   = 2'd2;
  localparam logic [1:0] SEC_RODATA = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_BASE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_LENGTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_LENGTH = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] write_address;
    logic [WORD_W-1:0] write_value;
    logic              final_write;
  } result_t;

endpackage

// ----- hdl/mips_overlay_relocator.sv -----
// Each input word is registered in the work stage on accept; its result words in out_r.
// One entry per cycle unless output stalls; a LO16 entry holds the stage for two writes.
// The HI16 table sits in one RAM; its read is issued at input accept, a row per entry.
// Reset (synchronous, rst_n low) clears configuration, pipeline valids and the table's
// per-row valid bits at once; an invalid row reads as zero. No clearing pass.
// Depends on mor_pkg, mor_ram and assert_macros.svh.
`include "assert_macros.svh"

module mips_overlay_relocator #(
  parameter int REG_COUNT = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [63:0]                    in_tdata,   // reloc_entry, target_word
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [63:0]                    out_tdata,  // write_address, write_value
  output logic                           out_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mor_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data
);
  import mor_pkg::*;

  localparam int IDX_W = $clog2(REG_COUNT);
  localparam int ROW_W = WORD_W + ADDR_W;

  // configuration
  logic [31:0] load_base_r, link_base_r, load_base_nxt, link_base_nxt;
  logic [23:0] text_len_r, data_len_r, text_len_nxt, data_len_nxt;
  logic [31:0] base_data_r, base_rodata_r, base_data_nxt, base_rodata_nxt;
  logic [31:0] delta_r, delta_nxt;
  logic        cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;

  always_comb begin
    load_base_nxt = load_base_r;
    link_base_nxt = link_base_r;
    text_len_nxt  = text_len_r;
    data_len_nxt  = data_len_r;
    unique case (cfg_index)
      CFG_LOAD_BASE:   load_base_nxt = cfg_data;
      CFG_LINK_BASE:   link_base_nxt = cfg_data;
      CFG_TEXT_LENGTH: text_len_nxt  = cfg_data[23:0];
      CFG_DATA_LENGTH: data_len_nxt  = cfg_data[23:0];
      default: ;
    endcase
    base_data_nxt   = load_base_nxt + {8'd0, text_len_nxt};
    base_rodata_nxt = base_data_nxt + {8'd0, data_len_nxt};
    delta_nxt       = load_base_nxt - link_base_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_base_r   <= '0;
      link_base_r   <= '0;
      text_len_r    <= '0;
      data_len_r    <= '0;
      base_data_r   <= '0;
      base_rodata_r <= '0;
      delta_r       <= '0;
    end else if (cfg_fire) begin
      load_base_r   <= load_base_nxt;
      link_base_r   <= link_base_nxt;
      text_len_r    <= text_len_nxt;
      data_len_r    <= data_len_nxt;
      base_data_r   <= base_data_nxt;
      base_rodata_r <= base_rodata_nxt;
      delta_r       <= delta_nxt;
    end
  end

  // work stage
  logic                 s1_valid_r, phase_r;
  logic [ENTRY_W-1:0]   s1_entry_r;
  logic [WORD_W-1:0]    s1_word_r;
  logic                 s1_last_r;
  logic                 rd_valid_r, fwd_r;
  logic [ROW_W-1:0]     fwd_data_r;
  logic [REG_COUNT-1:0] row_valid_r;

  logic                 in_fire, out_free, push, last_push, s1_retire, clr;
  logic [1:0]           n_res;
  logic [5:0]           rtype;
  logic [ADDR_W-1:0]    sec_base, addr;
  logic                 ram_we, hit;
  logic [IDX_W-1:0]     ram_waddr, ram_raddr;
  logic [ROW_W-1:0]     ram_wdata, ram_rdata, row;
  logic [WORD_W-1:0]    hw, hi_addr;
  logic [31:0]          w_reloc, j_tgt, j_reloc, comb, l_reloc, hiv;
  logic [16:0]          hi_sum;
  result_t              res, out_r;

  assign rtype = s1_entry_r[29:24];

  always_comb begin
    case (s1_entry_r[31:30])
      SEC_NULL: sec_base = '0;
      SEC_TEXT: sec_base = load_base_r;
      SEC_DATA: sec_base = base_data_r;
      default:  sec_base = base_rodata_r;
    endcase
  end
  assign addr = sec_base + {8'd0, s1_entry_r[23:0]};

  assign row     = !rd_valid_r ? '0 : (fwd_r ? fwd_data_r : ram_rdata);
  assign hw      = row[ROW_W-1 -: WORD_W];
  assign hi_addr = row[ADDR_W-1:0];

  assign w_reloc = s1_word_r + delta_r;
  assign j_tgt   = {4'b1000, s1_word_r[25:0], 2'b00};
  assign j_reloc = j_tgt + delta_r;
  assign comb    = {hw[15:0], 16'd0} + {{16{s1_word_r[15]}}, s1_word_r[15:0]};
  assign l_reloc = {hw[15:0], 16'd0} + {{16{s1_word_r[15]}}, s1_word_r[15:0]} + delta_r;
  assign hi_sum  = {1'b0, l_reloc[31:16]} + {16'd0, l_reloc[15]};
  assign hiv     = {hw[31:16], 16'd0} | {15'd0, hi_sum};

  always_comb begin
    n_res = 2'd0;
    res   = '{write_address: addr, write_value: w_reloc, final_write: 1'b1};
    unique case (rtype)
      RT_WORD32: begin
        n_res = (s1_word_r[27:24] == 4'd0) ? 2'd1 : 2'd0;
      end
      RT_JUMP26: begin
        n_res = 2'd1;
        res.write_value = {s1_word_r[31:26], j_reloc[27:2]};
      end
      RT_LO16: begin
        n_res = (comb[27:24] == 4'd0) ? 2'd2 : 2'd0;
        if (!phase_r) begin
          res = '{write_address: hi_addr, write_value: hiv, final_write: 1'b0};
        end else begin
          res.write_value = {s1_word_r[31:16], l_reloc[15:0]};
        end
      end
      default: n_res = 2'd0;
    endcase
  end

  assign out_free  = !out_tvalid || out_tready;
  assign push      = s1_valid_r && (n_res != 2'd0) && out_free;
  assign last_push = push && ((n_res == 2'd1) || phase_r);
  assign s1_retire = s1_valid_r && ((n_res == 2'd0) || last_push);
  assign in_tready = !s1_valid_r || s1_retire;
  assign in_fire   = in_tvalid && in_tready;
  assign clr       = s1_retire && s1_last_r;

  // table access: write on HI16 retire, read at accept, forward a same-row write
  assign ram_we    = s1_retire && (rtype == RT_HI16);
  assign ram_waddr = s1_word_r[16 +: IDX_W];
  assign ram_wdata = {s1_word_r, addr};
  assign ram_raddr = in_tdata[32 + 21 +: IDX_W];
  assign hit       = ram_we && (ram_waddr == ram_raddr);

  mor_ram #(
    .WIDTH(ROW_W),
    .DEPTH(REG_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      phase_r     <= 1'b0;
      row_valid_r <= '0;
      out_tvalid  <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_retire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_retire) begin
        phase_r <= 1'b0;
      end else if (push) begin
        phase_r <= 1'b1;
      end
      if (clr) begin
        row_valid_r <= '0;
      end else if (ram_we) begin
        row_valid_r[ram_waddr] <= 1'b1;
      end
      if (push) begin
        out_tvalid <= 1'b1;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_entry_r <= in_tdata[31:0];
      s1_word_r  <= in_tdata[63:32];
      s1_last_r  <= in_tlast;
      rd_valid_r <= !clr && (row_valid_r[ram_raddr] || hit);
      fwd_r      <= hit;
      fwd_data_r <= ram_wdata;
    end
    if (push) begin
      out_r <= res;
    end
  end

  assign out_tdata = {out_r.write_value, out_r.write_address};
  assign out_tlast = out_r.final_write;

  `MOR_ASSERT_IMPL(a_accept_free, in_fire, !s1_valid_r || s1_retire, "accept into busy stage")
  `MOR_ASSERT_IMPL(a_write_retire, ram_we, s1_retire, "table write without retire")
  `MOR_ASSERT_NEXT(a_clear_table, clr, row_valid_r == '0, "table not cleared after last")
  `MOR_ASSERT_IMPL(a_phase_lo16, phase_r, s1_valid_r && (rtype == RT_LO16), "second write not LO16")

endmodule

// ----- hdl/mor_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mor_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- tb/mips_overlay_relocator_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for mips_overlay_relocator: relocation words in, memory writes out.
// Predicts writes from its copy of base registers and HI16 table, unless a row lists them.
// Depends on mor_pkg and the relocator RTL.
module mips_overlay_relocator_tb;
  import mor_pkg::*;

  localparam int HI_DEPTH = 32;
  localparam logic [5:0] RT_REL32   = 6'd3;
  localparam logic [5:0] RT_GPREL16 = 6'd7;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam result_t NO_WRITE = '0;

  typedef struct {
    logic [31:0] entry;
    logic [31:0] word;
    logic        last;
    int          n;
    result_t     w0;
    result_t     w1;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  logic [31:0] load_base = '0;
  logic [31:0] link_base = '0;
  logic [23:0] text_length = '0;
  logic [23:0] data_length = '0;
  logic [31:0] lui_word_tbl [HI_DEPTH];
  logic [31:0] lui_addr_tbl [HI_DEPTH];

  result_t pending_writes[$];
  result_t step_writes[2];
  int      mismatch_count = 0;
  int      sender_idle_pct = 0;
  int      recv_stall_pct = 0;
  logic    hold_token = 1'b0;
  logic    hold_seen = 1'b0;
  int      hold_left = 0;

  mips_overlay_relocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [31:0] mk_entry(input logic [1:0] sec, input logic [5:0] kind,
                                           input logic [23:0] off);
    return {sec, kind, off};
  endfunction

  function automatic result_t mem_write(input logic [31:0] a, input logic [31:0] v,
                                        input logic f);
    result_t w;
    w.write_address = a;
    w.write_value   = v;
    w.final_write   = f;
    return w;
  endfunction

  function automatic logic [31:0] rebase(input logic [31:0] a);
    return a - link_base + load_base;
  endfunction

  function automatic int predict_writes(input logic [31:0] entry, input logic [31:0] word,
                                        input logic last);
    logic [31:0] base;
    logic [31:0] addr;
    logic [31:0] r;
    logic [31:0] hw;
    logic [31:0] comb;
    logic [4:0]  k;
    int          n;
    n = 0;
    case (entry[31:30])
      SEC_NULL: base = '0;
      SEC_TEXT: base = load_base;
      SEC_DATA: base = load_base + {8'h00, text_length};
      default:  base = load_base + {8'h00, text_length} + {8'h00, data_length};
    endcase
    addr = base + {8'h00, entry[23:0]};
    case (entry[29:24])
      RT_WORD32: begin
        if (word[27:24] == 4'h0) begin
          step_writes[0] = mem_write(addr, rebase(word), 1'b1);
          n = 1;
        end
      end
      RT_JUMP26: begin
        r = rebase({4'h8, word[25:0], 2'b00});
        step_writes[0] = mem_write(addr, {word[31:26], r[27:2]}, 1'b1);
        n = 1;
      end
      RT_HI16: begin
        k = word[20:16];
        lui_word_tbl[k] = word;
        lui_addr_tbl[k] = addr;
      end
      RT_LO16: begin
        k = word[25:21];
        hw = lui_word_tbl[k];
        comb = {hw[15:0], 16'h0000} + {{16{word[15]}}, word[15:0]};
        if (comb[27:24] == 4'h0) begin
          r = rebase(comb);
          step_writes[0] = mem_write(lui_addr_tbl[k],
                                     (hw & 32'hFFFF_0000) | ({16'h0, r[31:16]} + {31'h0, r[15]}),
                                     1'b0);
          step_writes[1] = mem_write(addr, {word[31:16], r[15:0]}, 1'b1);
          n = 2;
        end
      end
      default: ;
    endcase
    if (last) begin
      for (int i = 0; i < HI_DEPTH; i++) begin
        lui_word_tbl[i] = '0;
        lui_addr_tbl[i] = '0;
      end
    end
    return n;
  endfunction

  task automatic check_write();
    result_t exp_w;
    if (pending_writes.size() == 0) begin
      $error("unexpected write: write_address %h write_value %h final_write %b",
             out_tdata[31:0], out_tdata[63:32], out_tlast);
      mismatch_count++;
    end else begin
      exp_w = pending_writes.pop_front();
      if (out_tdata[31:0] !== exp_w.write_address) begin
        $error("write_address: expected %h, got %h", exp_w.write_address, out_tdata[31:0]);
        mismatch_count++;
      end
      if (out_tdata[63:32] !== exp_w.write_value) begin
        $error("write_value: expected %h, got %h", exp_w.write_value, out_tdata[63:32]);
        mismatch_count++;
      end
      if (out_tlast !== exp_w.final_write) begin
        $error("final_write: expected %b, got %b", exp_w.final_write, out_tlast);
        mismatch_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      check_write();
    end
    if (hold_token != hold_seen) begin
      hold_seen  <= hold_token;
      hold_left  <= 150;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic send_entry(input logic [31:0] entry, input logic [31:0] word, input logic last,
                            input int typed_n = -1, input result_t typed0 = '0,
                            input result_t typed1 = '0);
    int n;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {word, entry};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    n = predict_writes(entry, word, last);
    if (typed_n < 0) begin
      for (int i = 0; i < n; i++) pending_writes.push_back(step_writes[i]);
    end else begin
      if (typed_n > 0) pending_writes.push_back(typed0);
      if (typed_n > 1) pending_writes.push_back(typed1);
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_regs(input logic [31:0] load_v, input logic [31:0] link_v,
                              input logic [31:0] text_v, input logic [31:0] data_v);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [31:0] vals [4];
    idx  = '{CFG_LOAD_BASE, CFG_LINK_BASE, CFG_TEXT_LENGTH, CFG_DATA_LENGTH};
    vals = '{load_v, link_v, text_v, data_v};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        CFG_LOAD_BASE:   load_base = vals[i];
        CFG_LINK_BASE:   link_base = vals[i];
        CFG_TEXT_LENGTH: text_length = vals[i][23:0];
        default:         data_length = vals[i][23:0];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic coin(input int n);
    return $urandom_range(0, n - 1) == 0;
  endfunction

  function automatic logic [23:0] any_offset();
    logic [23:0] off;
    off = 24'($urandom);
    if (coin(2)) off = {12'h000, off[11:2], 2'b00};
    return off;
  endfunction

  function automatic logic [31:0] lui_word(input logic [4:0] k);
    logic [31:0] w;
    w = $urandom;
    if (!coin(5)) w[11:8] = 4'h0;
    return {OP_LUI, w[25:21], k, w[15:0]};
  endfunction

  function automatic logic [31:0] lo_word(input logic [4:0] k);
    logic [31:0] w;
    w = $urandom;
    return {w[31:26], k, w[20:0]};
  endfunction

  task automatic run_random_burst(input int count);
    int sent;
    int pick;
    int reps;
    logic [4:0]  k;
    logic [31:0] w;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        k = 5'($urandom);
        send_entry(mk_entry(2'($urandom), RT_HI16, any_offset()), lui_word(k), coin(20));
        reps = $urandom_range(1, 3);
        repeat (reps) begin
          send_entry(mk_entry(2'($urandom), RT_LO16, any_offset()), lo_word(k), coin(20));
        end
        sent += reps + 1;
      end else if (pick < 65) begin
        w = $urandom;
        if (!coin(5)) w[27:24] = 4'h0;
        send_entry(mk_entry(2'($urandom), RT_WORD32, any_offset()), w, coin(16));
        sent++;
      end else if (pick < 80) begin
        send_entry(mk_entry(2'($urandom), RT_JUMP26, any_offset()), $urandom, coin(16));
        sent++;
      end else if (pick < 92) begin
        send_entry(mk_entry(2'($urandom), RT_LO16, any_offset()), lo_word(5'($urandom)),
                   coin(16));
        sent++;
      end else begin
        send_entry($urandom, $urandom, coin(16));
        sent++;
      end
    end
  endtask

  initial begin
    row_t dir_rows [21];
    for (int i = 0; i < HI_DEPTH; i++) begin
      lui_word_tbl[i] = '0;
      lui_addr_tbl[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dir_rows = '{
      '{mk_entry(SEC_TEXT, RT_WORD32, 24'h000010), 32'h0000_1234, 1'b0, 1,
        mem_write(32'h0000_0010, 32'h0000_1234, 1'b1), NO_WRITE},
      '{mk_entry(SEC_NULL, RT_WORD32, 24'h000014), 32'h0F00_0000, 1'b0, 0, NO_WRITE, NO_WRITE},
      '{mk_entry(SEC_RODATA, RT_WORD32, 24'hFFFFFC), 32'hF0FF_FFFF, 1'b0, 1,
        mem_write(32'h00FF_FFFC, 32'hF0FF_FFFF, 1'b1), NO_WRITE},
      '{mk_entry(SEC_DATA, RT_JUMP26, 24'h000200), 32'h0000_0000, 1'b0, 1,
        mem_write(32'h0000_0200, 32'h0000_0000, 1'b1), NO_WRITE},
      '{mk_entry(SEC_TEXT, RT_JUMP26, 24'hFFFFFF), 32'hFFFF_FFFF, 1'b0, 1,
        mem_write(32'h00FF_FFFF, 32'hFFFF_FFFF, 1'b1), NO_WRITE},
      '{mk_entry(SEC_NULL, RT_LO16, 24'h000020), 32'h2464_0010, 1'b0, 2,
        mem_write(32'h0000_0000, 32'h0000_0000, 1'b0),
        mem_write(32'h0000_0020, 32'h2464_0010, 1'b1)},
      '{mk_entry(SEC_TEXT, RT_HI16, 24'h000100), 32'h3C05_8040, 1'b0, 0, NO_WRITE, NO_WRITE},
      '{mk_entry(SEC_DATA, RT_LO16, 24'h000104), 32'h24A5_8010, 1'b0, -1, NO_WRITE, NO_WRITE},
      '{mk_entry(SEC_RODATA, RT_LO16, 24'h000108), 32'h24A6_7FFC, 1'b0, -1, NO_WRITE, NO_WRITE},
      '{mk_entry(SEC_TEXT, RT_LO16, 24'h00010C), 32'h24A5_FFFF, 1'b0, -1, NO_WRITE, NO_WRITE},
      '{32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 0, NO_WRITE, NO_WRITE},
      '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 0, NO_WRITE, NO_WRITE},
      '{mk_entry(SEC_DATA, RT_REL32, 24'h123456), 32'h0000_0040, 1'b0, 0, NO_WRITE, NO_WRITE},
      '{mk_entry(SEC_TEXT, RT_GPREL16, 24'h000000), 32'h0000_0040, 1'b0, 0, NO_WRITE, NO_WRITE},
      '{mk_entry(SEC_RODATA, RT_HI16, 24'hFFFFFF), 32'h03E0_FFFF, 1'b0, 0, NO_WRITE, NO_WRITE},
      '{mk_entry(SEC_NULL, RT_LO16, 24'hFFFFFF), 32'h0000_FFFF, 1'b0, -1, NO_WRITE, NO_WRITE},
      '{mk_entry(SEC_TEXT, RT_HI16, 24'h000040), 32'h3C1F_8000, 1'b1, 0, NO_WRITE, NO_WRITE},
      '{mk_entry(SEC_NULL, RT_LO16, 24'h000044), 32'h27FF_0004, 1'b0, 2,
        mem_write(32'h0000_0000, 32'h0000_0000, 1'b0),
        mem_write(32'h0000_0044, 32'h27FF_0004, 1'b1)},
      '{mk_entry(SEC_TEXT, RT_HI16, 24'h000050), 32'h3C02_0F00, 1'b0, 0, NO_WRITE, NO_WRITE},
      '{mk_entry(SEC_NULL, RT_LO16, 24'h000054), 32'h2443_0000, 1'b0, 0, NO_WRITE, NO_WRITE},
      '{mk_entry(SEC_TEXT, RT_WORD32, 24'h000018), 32'h0000_0008, 1'b1, 1,
        mem_write(32'h0000_0018, 32'h0000_0008, 1'b1), NO_WRITE}
    };
    foreach (dir_rows[i]) begin
      send_entry(dir_rows[i].entry, dir_rows[i].word, dir_rows[i].last,
                 dir_rows[i].n, dir_rows[i].w0, dir_rows[i].w1);
    end
    settle();

    program_regs(32'h0000_0000, 32'h0001_0000, 32'h0000_1000, 32'h0000_0800);
    send_entry(mk_entry(SEC_NULL, RT_HI16, 24'h000000), 32'h3C06_0001, 1'b0);
    send_entry(mk_entry(SEC_TEXT, RT_LO16, 24'h000004), 32'h24C6_8000, 1'b0);
    settle();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       program_regs('1, '1, 32'h00FF_FFFF, 32'h00FF_FFFF);
        3:       program_regs('0, '1, '0, 32'h00FF_FFFF);
        default: program_regs($urandom, $urandom, $urandom, $urandom);
      endcase
      case (phase % 4)
        0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin sender_idle_pct = 47; recv_stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin sender_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      if (phase == 4) hold_token <= ~hold_token;
      run_random_burst(105);
      settle();
    end

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
